// ----- hw/rtl/safs_pkg.sv -----
package safs_pkg;

  localparam int FRAME_BITS = 10;
  localparam int SIZE_BITS  = 12;
  localparam int TIME_BITS  = 24;
  localparam int ACC_BITS   = 32;

  localparam int SIZE_W     = SIZE_BITS + 1;
  localparam int COLS_W     = FRAME_BITS + 1;
  localparam int RECT_W     = FRAME_BITS + SIZE_BITS + 1;
  localparam int CFG_DATA_W = TIME_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CNT_W      = $clog2(FRAME_BITS);

  // register reset values
  localparam logic [SIZE_W-1:0]     FRAME_WIDTH_RST   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0]     FRAME_HEIGHT_RST  = SIZE_W'(2);
  localparam logic [COLS_W-1:0]     SHEET_COLUMNS_RST = COLS_W'(1);
  localparam logic [FRAME_BITS-1:0] START_FRAME_RST   = '0;
  localparam logic [FRAME_BITS-1:0] END_FRAME_RST     = '0;
  localparam logic [TIME_BITS-1:0]  FRAME_DELAY_RST   = TIME_BITS'(65536);
  localparam logic                  LOOP_ENABLE_RST   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_SHEET_COLUMNS = 3'd2,
    CFG_START_FRAME   = 3'd3,
    CFG_END_FRAME     = 3'd4,
    CFG_FRAME_DELAY   = 3'd5,
    CFG_LOOP_ENABLE   = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef struct packed {
    logic [SIZE_W-1:0]     frame_width;
    logic [SIZE_W-1:0]     frame_height;
    logic [COLS_W-1:0]     sheet_columns;
    logic [FRAME_BITS-1:0] start_frame;
    logic [FRAME_BITS-1:0] end_frame;
    logic [TIME_BITS-1:0]  frame_delay;
    logic                  loop_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic step;
    logic dinit;
    logic dstep;
    logic mul;
    logic emit;
  } cmd_t;

endpackage

// ----- hw/rtl/safs_ctrl.sv -----
module safs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_free,
  output safs_pkg::cmd_t  cmd
);
  import safs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_STEP,
    S_DINIT,
    S_DIV,
    S_MUL,
    S_SUM
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             div_last;

  assign div_last = (cnt_r == CNT_W'(FRAME_BITS - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_ACC;
      S_ACC:   state_nxt = S_STEP;
      S_STEP:  state_nxt = S_DINIT;
      S_DINIT: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_last) state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.acc   = (state_r == S_ACC);
  assign cmd.step  = (state_r == S_STEP);
  assign cmd.dinit = (state_r == S_DINIT);
  assign cmd.dstep = (state_r == S_DIV);
  assign cmd.mul   = (state_r == S_MUL);
  assign cmd.emit  = (state_r == S_SUM) && out_free;

`ifndef SYNTHESIS
  // multiply only after the full run of divider steps
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> ($past(state_r) == S_DIV && $past(cnt_r) == CNT_W'(FRAME_BITS - 1)))
    else $error("multiply entered before divider finished");

  // a delivered result frees the controller for the next item
  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> in_ready)
    else $error("controller not ready after emitting a result");

  // divide step counter stays inside the quotient width
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(FRAME_BITS)))
    else $error("divide step count out of range");
`endif

endmodule

// ----- hw/rtl/safs_dp.sv -----
module safs_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  safs_pkg::cmd_t                    cmd,
  input  safs_pkg::cfg_t                    cfg,
  input  logic                              in_operation,
  input  logic [safs_pkg::TIME_BITS-1:0]    in_elapsed_time,
  input  logic [safs_pkg::FRAME_BITS-1:0]   in_new_frame,
  output logic                              out_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [safs_pkg::FRAME_BITS-1:0]   out_frame_number,
  output logic                              out_complete_flag,
  output logic [safs_pkg::RECT_W-1:0]       out_rect_left,
  output logic [safs_pkg::RECT_W-1:0]       out_rect_top,
  output logic [safs_pkg::RECT_W-1:0]       out_rect_right,
  output logic [safs_pkg::RECT_W-1:0]       out_rect_bottom
);
  import safs_pkg::*;

  // latched item
  op_t                   op_r, op_nxt;
  logic [TIME_BITS-1:0]  dt_r, dt_nxt;
  logic [FRAME_BITS-1:0] nf_r, nf_nxt;

  // animation state
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  fin_r, fin_nxt;

  // divider
  logic [FRAME_BITS-1:0] rem_r, rem_nxt;
  logic [FRAME_BITS-1:0] quo_r, quo_nxt;
  logic [COLS_W-1:0]     div_r, div_nxt;

  // products
  logic [RECT_W-1:0]     left_r, left_nxt;
  logic [RECT_W-1:0]     top_r, top_nxt;

  // output slot
  logic                  ov_r, ov_nxt;
  logic [FRAME_BITS-1:0] oframe_r, oframe_nxt;
  logic                  ofin_r, ofin_nxt;
  logic [RECT_W-1:0]     oleft_r, oleft_nxt;
  logic [RECT_W-1:0]     otop_r, otop_nxt;
  logic [RECT_W-1:0]     oright_r, oright_nxt;
  logic [RECT_W-1:0]     obot_r, obot_nxt;

  logic                  animated;
  logic [ACC_BITS:0]     acc_sum;
  logic [ACC_BITS-1:0]   acc_sat;
  logic                  advance;
  logic [FRAME_BITS:0]   frame_inc;
  logic                  out_of_range;
  logic [COLS_W-1:0]     divisor;
  logic [COLS_W-1:0]     trial;
  logic [COLS_W-1:0]     diff;
  logic                  fits;

  assign animated     = (cfg.end_frame > cfg.start_frame);
  assign acc_sum      = {1'b0, acc_r} + (ACC_BITS + 1)'(dt_r);
  assign acc_sat      = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
  assign advance      = (acc_r > ACC_BITS'(cfg.frame_delay));
  // one bit wider so the top frame plus one leaves the range
  assign frame_inc    = {1'b0, frame_r} + (FRAME_BITS + 1)'(1);
  assign out_of_range = (frame_inc < {1'b0, cfg.start_frame}) ||
                        (frame_inc > {1'b0, cfg.end_frame});
  assign divisor      = (cfg.sheet_columns == '0) ? COLS_W'(1) : cfg.sheet_columns;
  assign trial        = {rem_r, quo_r[FRAME_BITS-1]};
  assign fits         = (trial >= div_r);
  assign diff         = trial - div_r;

  assign out_free     = !ov_r || out_ready;

  always_comb begin
    op_nxt     = op_r;
    dt_nxt     = dt_r;
    nf_nxt     = nf_r;
    acc_nxt    = acc_r;
    frame_nxt  = frame_r;
    fin_nxt    = fin_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    div_nxt    = div_r;
    left_nxt   = left_r;
    top_nxt    = top_r;
    oframe_nxt = oframe_r;
    ofin_nxt   = ofin_r;
    oleft_nxt  = oleft_r;
    otop_nxt   = otop_r;
    oright_nxt = oright_r;
    obot_nxt   = obot_r;
    ov_nxt     = out_ready ? 1'b0 : ov_r;

    if (cmd.load) begin
      op_nxt = op_t'(in_operation);
      dt_nxt = in_elapsed_time;
      nf_nxt = in_new_frame;
    end

    if (cmd.acc) begin
      if (op_r == OP_SET) begin
        frame_nxt = nf_r;
        fin_nxt   = 1'b0;
      end else if (animated) begin
        acc_nxt = acc_sat;
      end
    end

    if (cmd.step && op_r == OP_TICK && animated && advance) begin
      acc_nxt = acc_r - ACC_BITS'(cfg.frame_delay);
      if (out_of_range) begin
        if (cfg.loop_enable) begin
          frame_nxt = cfg.start_frame;
        end else begin
          frame_nxt = cfg.end_frame;
          fin_nxt   = 1'b1;
        end
      end else begin
        frame_nxt = frame_inc[FRAME_BITS-1:0];
      end
    end

    if (cmd.dinit) begin
      rem_nxt = '0;
      quo_nxt = frame_r;
      div_nxt = divisor;
    end

    // restoring division, one quotient bit per cycle
    if (cmd.dstep) begin
      quo_nxt = {quo_r[FRAME_BITS-2:0], fits};
      rem_nxt = fits ? diff[FRAME_BITS-1:0] : trial[FRAME_BITS-1:0];
    end

    if (cmd.mul) begin
      left_nxt = RECT_W'(rem_r) * RECT_W'(cfg.frame_width);
      top_nxt  = RECT_W'(quo_r) * RECT_W'(cfg.frame_height);
    end

    if (cmd.emit) begin
      ov_nxt     = 1'b1;
      oframe_nxt = frame_r;
      ofin_nxt   = fin_r;
      oleft_nxt  = left_r;
      otop_nxt   = top_r;
      oright_nxt = left_r + RECT_W'(cfg.frame_width);
      obot_nxt   = top_r + RECT_W'(cfg.frame_height);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      frame_r <= '0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      frame_r <= frame_nxt;
      fin_r   <= fin_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    dt_r     <= dt_nxt;
    nf_r     <= nf_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    div_r    <= div_nxt;
    left_r   <= left_nxt;
    top_r    <= top_nxt;
    oframe_r <= oframe_nxt;
    ofin_r   <= ofin_nxt;
    oleft_r  <= oleft_nxt;
    otop_r   <= otop_nxt;
    oright_r <= oright_nxt;
    obot_r   <= obot_nxt;
  end

  assign out_valid         = ov_r;
  assign out_frame_number  = oframe_r;
  assign out_complete_flag = ofin_r;
  assign out_rect_left     = oleft_r;
  assign out_rect_top      = otop_r;
  assign out_rect_right    = oright_r;
  assign out_rect_bottom   = obot_r;

`ifndef SYNTHESIS
  // complete only ever set while looping is off
  a_fin_no_loop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fin_r) |-> !cfg.loop_enable)
    else $error("complete set while looping");

  // divider leaves a remainder below the column count
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> (COLS_W'(rem_r) < div_r))
    else $error("divider remainder not below column count");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!ov_r || out_ready))
    else $error("result slot overwritten");
`endif

endmodule

// ----- hw/rtl/sprite_animation_frame_sequencer_top.sv -----
// channel   ports                                          handshake
// input     in_operation, in_elapsed_time, in_new_frame    in_valid / in_ready
// result    out_frame_number, out_complete_flag,           out_valid / out_ready
//           out_rect_left/top/right/bottom
// config    cfg_index, cfg_wdata                           cfg_we, no wait
//
// once an item is accepted its result is built in order: timer add, frame
// step, divider load, FRAME_BITS restoring divide steps, multiply, final add;
// the next item is taken only after the result has left the final add stage,
// and the serial column/row divider works one quotient bit per cycle
// a finished result sits in the output register while the next item runs; the
// final stage stalls only if that register is still full and not being taken
// rst_n is synchronous, active low; it restores the register reset values,
// frame 0, timer 0, complete clear, and no result pending
module sprite_animation_frame_sequencer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [safs_pkg::TIME_BITS-1:0]    in_elapsed_time,
  input  logic [safs_pkg::FRAME_BITS-1:0]   in_new_frame,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [safs_pkg::FRAME_BITS-1:0]   out_frame_number,
  output logic                              out_complete_flag,
  output logic [safs_pkg::RECT_W-1:0]       out_rect_left,
  output logic [safs_pkg::RECT_W-1:0]       out_rect_top,
  output logic [safs_pkg::RECT_W-1:0]       out_rect_right,
  output logic [safs_pkg::RECT_W-1:0]       out_rect_bottom,
  // configuration
  input  logic                              cfg_we,
  input  logic [safs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [safs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import safs_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  logic out_free;

  // register file; writes land on any edge; the host must keep them to idle periods, the block does not enforce it
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:   cfg_nxt.frame_width   = cfg_wdata[SIZE_W-1:0];
        CFG_FRAME_HEIGHT:  cfg_nxt.frame_height  = cfg_wdata[SIZE_W-1:0];
        CFG_SHEET_COLUMNS: cfg_nxt.sheet_columns = cfg_wdata[COLS_W-1:0];
        CFG_START_FRAME:   cfg_nxt.start_frame   = cfg_wdata[FRAME_BITS-1:0];
        CFG_END_FRAME:     cfg_nxt.end_frame     = cfg_wdata[FRAME_BITS-1:0];
        CFG_FRAME_DELAY:   cfg_nxt.frame_delay   = cfg_wdata[TIME_BITS-1:0];
        CFG_LOOP_ENABLE:   cfg_nxt.loop_enable   = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;  // unused index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= FRAME_WIDTH_RST;
      cfg_r.frame_height  <= FRAME_HEIGHT_RST;
      cfg_r.sheet_columns <= SHEET_COLUMNS_RST;
      cfg_r.start_frame   <= START_FRAME_RST;
      cfg_r.end_frame     <= END_FRAME_RST;
      cfg_r.frame_delay   <= FRAME_DELAY_RST;
      cfg_r.loop_enable   <= LOOP_ENABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencing: one item in flight, walked through the datapath steps
  safs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  // timer, frame stepping, column/row divider, rectangle math, result slot
  safs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg_r),
    .in_operation      (in_operation),
    .in_elapsed_time   (in_elapsed_time),
    .in_new_frame      (in_new_frame),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_number  (out_frame_number),
    .out_complete_flag (out_complete_flag),
    .out_rect_left     (out_rect_left),
    .out_rect_top      (out_rect_top),
    .out_rect_right    (out_rect_right),
    .out_rect_bottom   (out_rect_bottom)
  );

endmodule
